// ===== sv/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int CELL_W      = 16;
    localparam int CUR_ROW_W   = 5;
    localparam int CUR_COL_W   = 7;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] COLOR_DEFAULT = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL    = {COLOR_DEFAULT, CHAR_SPACE};

    typedef struct packed {
        logic [1:0]         opcode;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } tcw_in_t;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CUR_COL_W-1:0] cursor_col;
    } tcw_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic fill_en;
        logic fill_row;
        logic load_read;
    } tcw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scroll;
        logic fill_last;
    } tcw_stat_t;

endpackage

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic [1:0] opcode,
    input  wire tcw_stat_t stat,
    output tcw_cmd_t       cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_BLANK,
        ST_WIPE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        cmd.accept    = (state_reg == ST_IDLE) && start;
        cmd.fill_en   = (state_reg == ST_INIT) || (state_reg == ST_BLANK) ||
                        (state_reg == ST_WIPE);
        cmd.fill_row  = (state_reg == ST_BLANK);
        cmd.load_read = (state_reg == ST_READ);
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        OP_PUT:
                        begin
                            if (stat.scroll)
                            begin
                                state_next = ST_BLANK;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_CLEAR: state_next = ST_WIPE;
                        OP_READ:  state_next = ST_READ;
                        default:  done_next  = 1'b1;
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            ST_BLANK, ST_WIPE:
            begin
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/tcw_datapath.sv =====
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tcw_in_t           req,
    input  wire tcw_cmd_t          cmd,
    input  wire logic              cfg_we,
    input  wire logic [CHAR_W-1:0] cfg_data,
    output tcw_stat_t              stat,
    output tcw_out_t               rsp
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ADDR_W1    = ADDR_W + 1;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int SUM_W      = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

    // The store is addressed physically; the logical top row starts at base_reg,
    // so a scroll moves the base by one row instead of copying the store.
    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [ROW_W-1:0]  row_reg,   row_next;
    logic [COL_W-1:0]  col_reg,   col_next;
    logic [ADDR_W-1:0] base_reg,  base_next;
    logic [ADDR_W-1:0] rs_reg,    rs_next;
    logic [CHAR_W-1:0] color_reg, color_next;
    logic [ADDR_W-1:0] cnt_reg,   cnt_next;
    logic              read_ok_reg;
    logic [CELL_W-1:0] rd_data_reg;
    tcw_out_t          rsp_reg;

    logic              newline;
    logic              wrap;
    logic              last_row;
    logic [ADDR_W1-1:0] rs_sum;
    logic [ADDR_W1-1:0] base_sum;
    logic [ADDR_W-1:0] rs_wrap;
    logic [ADDR_W-1:0] base_wrap;
    logic [SUM_W-1:0]  idx_ext;
    logic [SUM_W-1:0]  phys_sum;
    logic [SUM_W-1:0]  phys;
    logic              in_range;
    logic              put_we;
    logic              rd_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic [ADDR_W-1:0] put_addr;
    logic [ADDR_W-1:0] fill_addr;

    assign newline  = (req.char_code == CHAR_NEWLINE);
    assign wrap     = newline || (col_reg == COL_W'(COLUMNS - 1));
    assign last_row = (row_reg == ROW_W'(ROWS - 1));

    assign rs_sum    = {1'b0, rs_reg} + ADDR_W1'(COLUMNS);
    assign base_sum  = {1'b0, base_reg} + ADDR_W1'(COLUMNS);
    assign rs_wrap   = (rs_sum == ADDR_W1'(CELL_COUNT)) ? '0 : rs_sum[ADDR_W-1:0];
    assign base_wrap = (base_sum == ADDR_W1'(CELL_COUNT)) ? '0 : base_sum[ADDR_W-1:0];

    assign idx_ext  = SUM_W'(req.cell_index);
    assign in_range = (idx_ext < SUM_W'(CELL_COUNT));
    assign phys_sum = idx_ext + SUM_W'(base_reg);
    assign phys     = (phys_sum >= SUM_W'(CELL_COUNT)) ? (phys_sum - SUM_W'(CELL_COUNT))
                                                       : phys_sum;

    assign stat.scroll    = (req.opcode == OP_PUT) && wrap && last_row;
    assign stat.fill_last = cmd.fill_row ? (cnt_reg == ADDR_W'(COLUMNS - 1))
                                         : (cnt_reg == ADDR_W'(CELL_COUNT - 1));

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        base_next  = base_reg;
        rs_next    = rs_reg;
        color_next = color_reg;
        cnt_next   = cnt_reg;
        put_we     = 1'b0;
        if (cmd.fill_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.accept)
        begin
            cnt_next = '0;
            case (req.opcode)
                OP_PUT:
                begin
                    put_we = !newline;
                    if (wrap)
                    begin
                        col_next = '0;
                        rs_next  = rs_wrap;
                        if (last_row)
                        begin
                            base_next = base_wrap;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    row_next   = '0;
                    col_next   = '0;
                    base_next  = '0;
                    rs_next    = '0;
                    color_next = COLOR_DEFAULT;
                end
                default:
                begin
                end
            endcase
        end
        else if (cfg_we)
        begin
            color_next = cfg_data;
        end
    end

    assign put_addr  = rs_reg + ADDR_W'(col_reg);
    assign fill_addr = cmd.fill_row ? (rs_reg + cnt_reg) : cnt_reg;
    assign mem_we    = cmd.fill_en || put_we;
    assign mem_wa    = cmd.fill_en ? fill_addr : put_addr;
    assign mem_wd    = cmd.fill_en ? (cmd.fill_row ? {color_reg, CHAR_SPACE} : BLANK_CELL)
                                   : {color_reg, req.char_code};
    assign rd_en     = cmd.accept && (req.opcode == OP_READ);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[phys[ADDR_W-1:0]];
            read_ok_reg <= in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
            rs_reg    <= '0;
            color_reg <= COLOR_DEFAULT;
            cnt_reg   <= '0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            base_reg  <= base_next;
            rs_reg    <= rs_next;
            color_reg <= color_next;
            cnt_reg   <= cnt_next;
        end
    end

    // The cursor does not move during a sweep, so the result word is loaded at
    // acceptance; a read fills in the cell once the store has answered.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rsp_reg.cell_data  <= '0;
            rsp_reg.cursor_row <= CUR_ROW_W'(row_next);
            rsp_reg.cursor_col <= CUR_COL_W'(col_next);
        end
        else if (cmd.load_read)
        begin
            rsp_reg.cell_data <= read_ok_reg ? rd_data_reg : '0;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== sv/text_console_writer_top.sv =====
`default_nettype none

// Text console writer. A command word is taken when start is high and busy is
// low; exactly one result word follows on rsp, marked by done for a single cycle,
// and it cannot be held off. A put that does not scroll and the unused opcode give
// their result in the cycle after acceptance; read cell answers after the
// registered read of the cell store and then the read state. A put that scrolls
// blanks the bottom row and clear screen blanks the whole store, one cell per
// cycle through the single write port. Scrolling moves a row offset rather than
// copying cells. After reset the block stays busy while it blanks the store;
// cfg_we writes the text color except when a command word is being accepted.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire tcw_in_t           req,
    output logic                   busy,
    output logic                   done,
    output tcw_out_t               rsp,
    input  wire logic              cfg_we,
    input  wire logic [CHAR_W-1:0] cfg_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;

    tcw_cmd_t  cmd;
    tcw_stat_t stat;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (req.opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .stat     (stat),
        .rsp      (rsp)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while the block is busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted word neither finished nor in progress");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.opcode == OP_READ) |=> ##1 done)
        else $error("read cell did not answer in two cycles");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.opcode == OP_READ &&
         32'(req.cell_index) >= 32'(CELL_COUNT)) |=> ##1 (rsp.cell_data == '0))
        else $error("read beyond the store returned a nonzero cell");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = ROWS * COLUMNS;
    localparam int PHASES      = 5;
    localparam int PHASE_WORDS = 180;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int MAX_REPORTS = 10;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    tcw_in_t             req = '0;
    logic                busy;
    logic                done;
    tcw_out_t            rsp;
    logic                cfg_we = 1'b0;
    logic [CHAR_W-1:0]   cfg_data = '0;

    // Shadow copy of the console: cell store, cursor and current attribute.
    logic [CELL_W-1:0]   shadow_cells [CELLS];
    int                  cur_row;
    int                  cur_col;
    logic [CHAR_W-1:0]   text_color;

    tcw_out_t            expected_rsp [$];
    int                  mismatches = 0;
    int                  results_seen = 0;
    int                  cycle_count = 0;

    typedef struct {
        tcw_in_t  word;
        int       reps;
        bit       fixed;
        tcw_out_t result;
    } script_row_t;

    script_row_t         script [$];

    always #2 clk = ~clk;

    text_console_writer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    function automatic void blank_screen();
        int i;
        for (i = 0; i < CELLS; i++)
        begin
            shadow_cells[i] = BLANK_CELL;
        end
        cur_row    = 0;
        cur_col    = 0;
        text_color = COLOR_DEFAULT;
    endfunction

    function automatic void advance_row();
        int i;
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            for (i = 0; i < CELLS - COLUMNS; i++)
            begin
                shadow_cells[i] = shadow_cells[i + COLUMNS];
            end
            // The freshly exposed bottom row takes the current attribute.
            for (i = CELLS - COLUMNS; i < CELLS; i++)
            begin
                shadow_cells[i] = {text_color, CHAR_SPACE};
            end
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic tcw_out_t console_step(input tcw_in_t w);
        tcw_out_t r;
        r = '0;
        case (w.opcode)
            OP_PUT:
            begin
                if (w.char_code == CHAR_NEWLINE)
                begin
                    advance_row();
                end
                else
                begin
                    shadow_cells[cur_row * COLUMNS + cur_col] = {text_color, w.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                    begin
                        advance_row();
                    end
                end
            end
            OP_CLEAR:
            begin
                blank_screen();
            end
            OP_READ:
            begin
                if (int'(w.cell_index) < CELLS)
                begin
                    r.cell_data = shadow_cells[w.cell_index];
                end
            end
            default:
            begin
            end
        endcase
        r.cursor_row = CUR_ROW_W'(cur_row);
        r.cursor_col = CUR_COL_W'(cur_col);
        return r;
    endfunction

    function automatic script_row_t row(input logic [1:0] op, input logic [7:0] ch,
                                        input int idx, input int reps, input bit fixed,
                                        input logic [15:0] data, input int r, input int c);
        script_row_t s;
        s.word.opcode       = op;
        s.word.char_code    = ch;
        s.word.cell_index   = INDEX_W'(idx);
        s.reps              = reps;
        s.fixed             = fixed;
        s.result.cell_data  = data;
        s.result.cursor_row = CUR_ROW_W'(r);
        s.result.cursor_col = CUR_COL_W'(c);
        return s;
    endfunction

    function automatic tcw_in_t random_word();
        tcw_in_t w;
        int      pick;
        w.char_code  = 8'($urandom);
        w.cell_index = 11'($urandom);
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            w.opcode = OP_PUT;
            if ($urandom_range(99) < 15)
            begin
                w.char_code = CHAR_NEWLINE;
            end
        end
        else if (pick < 90)
        begin
            w.opcode = OP_READ;
            if ($urandom_range(99) < 6)
            begin
                w.cell_index = INDEX_W'($urandom_range(2047, CELLS));
            end
            else
            begin
                w.cell_index = INDEX_W'($urandom_range(CELLS - 1, 0));
            end
        end
        else if (pick < 99)
        begin
            w.opcode = OP_UNUSED;
        end
        else
        begin
            w.opcode = OP_CLEAR;
        end
        return w;
    endfunction

    task automatic send_word(input tcw_in_t w, input bit use_fixed, input tcw_out_t fixed_rsp);
        tcw_out_t predicted;
        start <= 1'b1;
        req   <= w;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predicted = console_step(w);
        expected_rsp.push_back(use_fixed ? fixed_rsp : predicted);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_sender(input int pct);
        if ($urandom_range(99) == 0)
        begin
            drain_results();
        end
        else if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    endtask

    task automatic write_color(input logic [CHAR_W-1:0] value);
        repeat (3) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        text_color = value;
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("mismatch on word %0d: %s expected %h got %h",
                     results_seen, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        tcw_out_t want;
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                note_mismatch("unexpected word", 0, rsp);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.cell_data !== want.cell_data)
                begin
                    note_mismatch("cell_data", want.cell_data, rsp.cell_data);
                end
                if (rsp.cursor_row !== want.cursor_row)
                begin
                    note_mismatch("cursor_row", want.cursor_row, rsp.cursor_row);
                end
                if (rsp.cursor_col !== want.cursor_col)
                begin
                    note_mismatch("cursor_col", want.cursor_col, rsp.cursor_col);
                end
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int              phase;
        int              k;
        int              n;
        logic [CHAR_W-1:0] color;

        blank_screen();

        script.push_back(row(OP_READ,    8'h00, 0,    1, 1, BLANK_CELL, 0, 0));
        script.push_back(row(OP_READ,    8'hFF, 1999, 1, 1, BLANK_CELL, 0, 0));
        // Indexes past the end of the store read as zero.
        script.push_back(row(OP_READ,    8'h00, 2000, 1, 1, 16'h0000, 0, 0));
        script.push_back(row(OP_READ,    8'h00, 2047, 1, 1, 16'h0000, 0, 0));
        script.push_back(row(OP_UNUSED,  8'hFF, 2047, 1, 1, 16'h0000, 0, 0));
        script.push_back(row(OP_PUT,     8'h41, 0,    1, 1, 16'h0000, 0, 1));
        script.push_back(row(OP_PUT,     8'h00, 2047, 1, 1, 16'h0000, 0, 2));
        script.push_back(row(OP_PUT,     8'hFF, 0,    1, 1, 16'h0000, 0, 3));
        script.push_back(row(OP_READ,    8'h00, 0,    1, 1, 16'h0741, 0, 3));
        script.push_back(row(OP_READ,    8'h00, 2,    1, 1, 16'h07FF, 0, 3));
        // A newline moves the cursor but leaves the cell under it untouched.
        script.push_back(row(OP_PUT,     CHAR_NEWLINE, 0, 1, 1, 16'h0000, 1, 0));
        script.push_back(row(OP_READ,    8'h00, 80,   1, 1, BLANK_CELL, 1, 0));
        script.push_back(row(OP_CLEAR,   8'h41, 5,    1, 1, 16'h0000, 0, 0));
        script.push_back(row(OP_READ,    8'h00, 0,    1, 1, BLANK_CELL, 0, 0));
        // A full row of characters wraps to the next row.
        script.push_back(row(OP_PUT,     8'h5A, 0,    COLUMNS, 1, 16'h0000, 1, 0));
        script.push_back(row(OP_READ,    8'h00, 79,   1, 1, 16'h075A, 1, 0));
        script.push_back(row(OP_PUT,     CHAR_NEWLINE, 0, 23, 1, 16'h0000, 24, 0));
        script.push_back(row(OP_PUT,     8'h51, 0,    79, 1, 16'h0000, 24, 79));
        // Wrapping off the last row scrolls and blanks the bottom row.
        script.push_back(row(OP_PUT,     8'h51, 0,    1, 1, 16'h0000, 24, 0));
        script.push_back(row(OP_READ,    8'h00, 1920, 1, 1, BLANK_CELL, 24, 0));
        script.push_back(row(OP_READ,    8'h00, 1919, 1, 1, 16'h0751, 24, 0));
        script.push_back(row(OP_READ,    8'h00, 0,    1, 0, 16'h0000, 0, 0));
        script.push_back(row(OP_PUT,     CHAR_NEWLINE, 0, 1, 0, 16'h0000, 0, 0));
        script.push_back(row(OP_UNUSED,  CHAR_NEWLINE, 0, 1, 1, 16'h0000, 24, 0));
        script.push_back(row(OP_CLEAR,   8'h00, 0,    1, 1, 16'h0000, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The block blanks its store after reset; the first word waits on busy.
        for (k = 0; k < script.size(); k++)
        begin
            for (n = 1; n <= script[k].reps; n++)
            begin
                send_word(script[k].word, script[k].fixed && n == script[k].reps,
                          script[k].result);
            end
        end
        drain_results();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       color = 8'h00;
                1:       color = 8'hFF;
                default: color = 8'($urandom);
            endcase
            write_color(color);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                case (phase)
                    1, 4:    idle_sender(77);
                    2:       idle_sender(9);
                    default: idle_sender(0);
                endcase
                send_word(random_word(), 1'b0, '0);
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_rsp.size() == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== text_console_writer_top.f =====
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_datapath.sv
sv/text_console_writer_top.sv
tb/sv/testbench.sv
